/* rtl/thsl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thsl_pkg: shared types and constants of the toggle handshake serial link
// Holds the word size, the link mode codes and the beat structures that
// travel between the link's modules.
// ----------------------------------------------------------------------------
package thsl_pkg;

  // Number of bits in one word on the serial link (1 to DATA_W, which is 16).
  localparam int WORD_BITS = 16;
  // Width of the bit counter inside a word.
  localparam int CNT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  // Width of the word fields on the parallel channels.
  localparam int DATA_W    = 16;

  // Last bit position of a word, as a counter value.
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  // Beat kinds on the input channel.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SEND = 1'b1;

  // Link modes.
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SEND = 2'd1,
    MODE_RECV = 2'd2
  } thsl_mode_t;

  // One input beat.
  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] word_in;
    logic              rx_strobe;
    logic              rx_bit;
  } thsl_item_t;

  // One result beat.
  typedef struct packed {
    logic              tx_bit;
    logic              tx_strobe;
    logic              busy_res;
    logic [DATA_W-1:0] word_out;
    logic              word_valid;
    logic              send_done;
  } thsl_res_t;

endpackage

/* rtl/thsl_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thsl_in_if: input channel of the serial link
// Valid/ready channel that carries line samples and send requests.
// ----------------------------------------------------------------------------
interface thsl_in_if;
  logic                      valid;
  logic                      ready;
  logic                      kind;
  logic [thsl_pkg::DATA_W-1:0] word_in;
  logic                      rx_strobe;
  logic                      rx_bit;

  modport source (output valid, kind, word_in, rx_strobe, rx_bit, input ready);
  modport sink   (input valid, kind, word_in, rx_strobe, rx_bit, output ready);
endinterface

/* rtl/thsl_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thsl_out_if: result channel of the serial link
// Valid/ready channel that carries the line levels and the word status.
// ----------------------------------------------------------------------------
interface thsl_out_if;
  logic                      valid;
  logic                      ready;
  logic                      tx_bit;
  logic                      tx_strobe;
  logic                      busy_res;
  logic [thsl_pkg::DATA_W-1:0] word_out;
  logic                      word_valid;
  logic                      send_done;

  modport source (output valid, tx_bit, tx_strobe, busy_res, word_out, word_valid,
                  send_done, input ready);
  modport sink   (input valid, tx_bit, tx_strobe, busy_res, word_out, word_valid,
                  send_done, output ready);
endinterface

/* rtl/toggle_handshake_serial_link.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// toggle_handshake_serial_link: one end of a toggle handshake serial link
// Sends words bit serially by toggling a strobe per bit and waiting for the
// echo, and receives words from the partner, echoing each bit.
//
//   Channel   Direction  Beat contents
//   in_ch     in         kind, word_in, rx_strobe, rx_bit
//   out_ch    out        tx_bit, tx_strobe, busy_res, word_out, word_valid,
//                        send_done
//
// Every input beat yields exactly one result beat: the beat is captured in
// the input register, then the state update loads the result register. A
// new beat is accepted in every cycle while out_ch.ready is high.
// When out_ch.ready is low the result register holds and the input register
// fills, then in_ch.ready drops. Reset is synchronous, active low, and
// returns the link to idle with both own lines low.
// ----------------------------------------------------------------------------
module toggle_handshake_serial_link (
  input  logic      clk,
  input  logic      rst_n,
  thsl_in_if.sink   in_ch,
  thsl_out_if.source out_ch
);
  import thsl_pkg::*;

  logic       item_valid;
  thsl_item_t item;
  logic       take;

  // Input register.
  thsl_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // Link state and result register.
  thsl_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .take       (take),
    .out_ch     (out_ch)
  );
endmodule

/* rtl/thsl_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thsl_in_stage: input register of the serial link
// Captures one input beat and holds it until the link core takes it.
// ----------------------------------------------------------------------------
module thsl_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  thsl_in_if.sink              in_ch,
  input  logic                 take,
  output logic                 item_valid,
  output thsl_pkg::thsl_item_t item
);
  import thsl_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  thsl_item_t item_r;
  logic       load;

  // The register frees up in the same cycle that the core takes its beat.
  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload capture needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r.kind      <= in_ch.kind;
      item_r.word_in   <= in_ch.word_in;
      item_r.rx_strobe <= in_ch.rx_strobe;
      item_r.rx_bit    <= in_ch.rx_bit;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

/* rtl/thsl_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thsl_core: link state and result register
// Updates the link state for one beat per cycle unless the result register
// is held, and registers the result beat that goes out on the result channel.
// ----------------------------------------------------------------------------
module thsl_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  thsl_pkg::thsl_item_t item,
  output logic                 take,
  thsl_out_if.source           out_ch
);
  import thsl_pkg::*;

  thsl_mode_t           mode_r, mode_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] shift_r, shift_nxt;
  logic                 last_rx_r, last_rx_nxt;
  logic                 strobe_r, strobe_nxt;
  logic                 data_r, data_nxt;
  logic                 out_valid_r, out_valid_nxt;
  thsl_res_t            res_r, res_nxt;
  logic                 word_done;
  logic                 send_fin;
  logic [WORD_BITS-1:0] rx_base;
  logic [CNT_W-1:0]     rx_cnt;

  // A beat is processed whenever the result register is free or drains now.
  assign take = item_valid && (!out_valid_r || out_ch.ready);

  // Link state update for one beat.
  always_comb begin
    mode_nxt    = mode_r;
    cnt_nxt     = cnt_r;
    shift_nxt   = shift_r;
    last_rx_nxt = last_rx_r;
    strobe_nxt  = strobe_r;
    data_nxt    = data_r;
    word_done   = 1'b0;
    send_fin    = 1'b0;
    rx_base     = (mode_r == MODE_RECV) ? shift_r : '0;
    rx_cnt      = (mode_r == MODE_RECV) ? cnt_r : '0;
    if (item.kind == KIND_SEND) begin
      // A send request starts a word only when the link is idle.
      if (mode_r != MODE_SEND && mode_r != MODE_RECV) begin
        shift_nxt  = WORD_BITS'(item.word_in);
        cnt_nxt    = '0;
        mode_nxt   = MODE_SEND;
        data_nxt   = shift_nxt[WORD_BITS-1];
        strobe_nxt = ~strobe_r;
      end
    end else if (item.rx_strobe != last_rx_r) begin
      last_rx_nxt = item.rx_strobe;
      case (mode_r)
        MODE_SEND: begin
          // Partner echoed a bit: finish or drive the next bit, MSB first.
          if (cnt_r >= CNT_LAST) begin
            cnt_nxt  = '0;
            mode_nxt = MODE_IDLE;
            send_fin = 1'b1;
          end else begin
            cnt_nxt    = cnt_r + 1'b1;
            shift_nxt  = shift_r << 1;
            data_nxt   = shift_nxt[WORD_BITS-1];
            strobe_nxt = ~strobe_r;
          end
        end
        default: begin
          // Receive a bit, starting a fresh word when idle, and echo it.
          shift_nxt  = (rx_base << 1) | WORD_BITS'(item.rx_bit);
          data_nxt   = item.rx_bit;
          strobe_nxt = ~strobe_r;
          if (rx_cnt >= CNT_LAST) begin
            cnt_nxt   = '0;
            mode_nxt  = MODE_IDLE;
            word_done = 1'b1;
          end else begin
            cnt_nxt  = rx_cnt + 1'b1;
            mode_nxt = MODE_RECV;
          end
        end
      endcase
    end
  end

  // Result beat built from the updated state.
  always_comb begin
    res_nxt.tx_bit     = data_nxt;
    res_nxt.tx_strobe  = strobe_nxt;
    res_nxt.busy_res   = (mode_nxt == MODE_SEND) || (mode_nxt == MODE_RECV);
    res_nxt.word_out   = word_done ? DATA_W'(shift_nxt) : '0;
    res_nxt.word_valid = word_done;
    res_nxt.send_done  = send_fin;
  end

  // Result register occupancy.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // State registers advance together with the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      cnt_r       <= '0;
      shift_r     <= '0;
      last_rx_r   <= 1'b0;
      strobe_r    <= 1'b0;
      data_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        mode_r    <= mode_nxt;
        cnt_r     <= cnt_nxt;
        shift_r   <= shift_nxt;
        last_rx_r <= last_rx_nxt;
        strobe_r  <= strobe_nxt;
        data_r    <= data_nxt;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.tx_bit     = res_r.tx_bit;
  assign out_ch.tx_strobe  = res_r.tx_strobe;
  assign out_ch.busy_res   = res_r.busy_res;
  assign out_ch.word_out   = res_r.word_out;
  assign out_ch.word_valid = res_r.word_valid;
  assign out_ch.send_done  = res_r.send_done;

`ifndef SYNTH
  // A word cannot finish in both directions on the same beat.
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.word_valid && res_r.send_done))
    else $error("received word and send completion on the same beat");

  // The bit counter rests at zero while the link is idle.
  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (cnt_r == '0))
    else $error("bit counter not zero while idle");

  // A completed word leaves the link idle.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.word_valid || res_r.send_done)) |-> !res_r.busy_res)
    else $error("link still busy after a completed word");

  // Own strobe only moves when a beat is processed.
  a_strobe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(strobe_r))
    else $error("strobe changed without a beat");
`endif
endmodule
